### rtl/core/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the matrix-to-quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;
  localparam int DataWidthDefault = 16;
  localparam int FracBitsDefault  = 14;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;
endpackage

### rtl/core/rmq_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_stream_if
// Valid/ready channel carrying a packed payload word.
// ----------------------------------------------------------------------------
interface rmq_stream_if #(
  parameter int Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd four-branch rotation matrix to quaternion conversion, fixed point.
// ----------------------------------------------------------------------------
// Takes one word of nine matrix entries per cycle and returns one quaternion
// word per matrix, saturated to the word range, with a degenerate flag and
// identity output when the root argument is not positive. Input word layout,
// LSB first: entry_0_0, entry_0_1, ... entry_2_2, each DATA_WIDTH bits. Output
// word layout, LSB first: quat_w, quat_x, quat_y, quat_z, degenerate.
// Throughput is one matrix per cycle when the output is not stalled; the
// pipeline is the input stage, the bit-per-stage square root (RW/2 stages),
// the three shared-depth restoring dividers (one quotient bit per stage, MW
// stages) and the output register; a stall holds all stages.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
  parameter int DATA_WIDTH = rmq_pkg::DataWidthDefault,
  parameter int FRAC_BITS  = rmq_pkg::FracBitsDefault
) (
  input logic clk,
  input logic rst,
  rmq_stream_if.sink   in_ch,
  rmq_stream_if.source out_ch
);
  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int RW0 = DW + 3 + FB;
  localparam int RW  = RW0 + (RW0 % 2);
  localparam int SQS = RW / 2;
  localparam int HW  = SQS;
  localparam int NW  = DW + 2;
  localparam int MW  = NW + FB;
  localparam int DS  = MW;
  localparam int NS  = 2 + SQS + DS;
  localparam int SL  = SQS + DS + 1;

  logic adv;
  logic [NS:1] vld;
  assign adv = !vld[NS] || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: unpack, trace and branch
  logic signed [DW-1:0] e [9];
  always_comb begin
    for (int i = 0; i < 9; i++) e[i] = in_ch.data[i*DW +: DW];
  end

  logic signed [DW+2:0] tr_c, r_c;
  rmq_pkg::branch_t br_c;
  logic signed [DW+2:0] one_c;
  logic signed [NW-1:0] n0_c, n1_c, n2_c;
  always_comb begin
    one_c = (DW+3)'(1) <<< FB;
    tr_c = (DW+3)'(e[0]) + (DW+3)'(e[4]) + (DW+3)'(e[8]);
    if (tr_c > 0) begin
      br_c = rmq_pkg::BR_TRACE;
      r_c = tr_c + one_c;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      br_c = rmq_pkg::BR_X;
      r_c = one_c + (DW+3)'(e[0]) - (DW+3)'(e[4]) - (DW+3)'(e[8]);
    end else if (e[4] > e[8]) begin
      br_c = rmq_pkg::BR_Y;
      r_c = one_c + (DW+3)'(e[4]) - (DW+3)'(e[0]) - (DW+3)'(e[8]);
    end else begin
      br_c = rmq_pkg::BR_Z;
      r_c = one_c + (DW+3)'(e[8]) - (DW+3)'(e[0]) - (DW+3)'(e[4]);
    end
    unique case (br_c)
      rmq_pkg::BR_TRACE: begin
        n0_c = NW'(e[7]) - NW'(e[5]);
        n1_c = NW'(e[2]) - NW'(e[6]);
        n2_c = NW'(e[3]) - NW'(e[1]);
      end
      rmq_pkg::BR_X: begin
        n0_c = NW'(e[7]) - NW'(e[5]);
        n1_c = NW'(e[1]) + NW'(e[3]);
        n2_c = NW'(e[2]) + NW'(e[6]);
      end
      rmq_pkg::BR_Y: begin
        n0_c = NW'(e[2]) - NW'(e[6]);
        n1_c = NW'(e[1]) + NW'(e[3]);
        n2_c = NW'(e[5]) + NW'(e[7]);
      end
      default: begin
        n0_c = NW'(e[3]) - NW'(e[1]);
        n1_c = NW'(e[2]) + NW'(e[6]);
        n2_c = NW'(e[5]) + NW'(e[7]);
      end
    endcase
  end

  // per-stage payload
  rmq_pkg::branch_t br [1:SL];
  logic             dg [1:SL];
  logic [RW-1:0]    sq  [1:SQS];
  logic [RW-1:0]    res [1:SQS];
  logic [HW-1:0]    hh  [1:SL];
  logic             ng  [1:SL][3];
  logic [MW-1:0]    dq  [1:SL][3];
  logic [MW:0]      dr  [1:SL][3];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-1:1], in_ch.valid};
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (adv) begin
      br[1] <= br_c;
      dg[1] <= (r_c <= 0);
      sq[1] <= (r_c > 0) ? (RW'(r_c) << FB) : '0;
      res[1] <= '0;
      hh[1] <= '0;
      ng[1][0] <= n0_c[NW-1];
      ng[1][1] <= n1_c[NW-1];
      ng[1][2] <= n2_c[NW-1];
      dq[1][0] <= MW'(n0_c[NW-1] ? -n0_c : n0_c) << FB;
      dq[1][1] <= MW'(n1_c[NW-1] ? -n1_c : n1_c) << FB;
      dq[1][2] <= MW'(n2_c[NW-1] ? -n2_c : n2_c) << FB;
      for (int k = 0; k < 3; k++) dr[1][k] <= '0;
    end
  end

  // square root stages: one result bit each
  for (genvar g = 1; g <= SQS; g++) begin : g_sqrt
    logic [RW-1:0] rm, rt, bt;
    always_comb begin
      bt = RW'(1) << (2*(SQS-g));
      rm = sq[g];
      rt = res[g];
      if (rm >= rt + bt) begin
        rm = rm - (rt + bt);
        rt = (rt >> 1) + bt;
      end else begin
        rt = rt >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        br[g+1] <= br[g];
        dg[g+1] <= dg[g];
        hh[g+1] <= (g == SQS) ? HW'(rt) : hh[g];
        ng[g+1] <= ng[g];
        dq[g+1] <= dq[g];
        dr[g+1] <= dr[g];
      end
    end
    if (g < SQS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          sq[g+1] <= rm;
          res[g+1] <= rt;
        end
      end
    end
  end

  // divider stages: restoring, one quotient bit each, divisor s = 2h
  for (genvar g = SQS+1; g <= SQS+DS; g++) begin : g_div
    logic [MW-1:0] qn [3];
    logic [MW:0]   rn [3];
    logic [MW:0]   dv;
    logic [MW+1:0] tt;
    always_comb begin
      dv = (MW+1)'(hh[g]) << 1;
      for (int k = 0; k < 3; k++) begin
        tt = {dr[g][k], dq[g][k][MW-1]};
        if (tt >= {1'b0, dv}) begin
          tt = tt - {1'b0, dv};
          qn[k] = {dq[g][k][MW-2:0], 1'b1};
        end else begin
          qn[k] = {dq[g][k][MW-2:0], 1'b0};
        end
        rn[k] = tt[MW:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        br[g+1] <= br[g];
        dg[g+1] <= dg[g];
        hh[g+1] <= hh[g];
        ng[g+1] <= ng[g];
        dq[g+1] <= qn;
        dr[g+1] <= rn;
      end
    end
  end

  // output stage: saturate and route
  localparam logic [DW-1:0] WMax = {1'b0, {(DW-1){1'b1}}};
  logic [DW-1:0] qo [3];
  logic [DW-1:0] quar, qw, qx, qy, qz;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dq[SL][k] > MW'(WMax)) qo[k] = ng[SL][k] ? {1'b1, {(DW-1){1'b0}}} : WMax;
      else qo[k] = ng[SL][k] ? -DW'(dq[SL][k]) : DW'(dq[SL][k]);
    end
    quar = ((hh[SL] >> 1) > HW'(WMax)) ? WMax : DW'(hh[SL] >> 1);
    unique case (br[SL])
      rmq_pkg::BR_TRACE: begin qw = quar;  qx = qo[0]; qy = qo[1]; qz = qo[2]; end
      rmq_pkg::BR_X:     begin qw = qo[0]; qx = quar;  qy = qo[1]; qz = qo[2]; end
      rmq_pkg::BR_Y:     begin qw = qo[0]; qx = qo[1]; qy = quar;  qz = qo[2]; end
      default:           begin qw = qo[0]; qx = qo[1]; qy = qo[2]; qz = quar;  end
    endcase
    if (dg[SL]) begin
      qw = ((FB >= DW-1) ? WMax : DW'(1) << FB);
      qx = '0;
      qy = '0;
      qz = '0;
    end
  end

  logic [4*DW:0] obuf;
  always_ff @(posedge clk) begin
    if (adv) obuf <= {dg[SL], qz, qy, qx, qw};
  end
  assign out_ch.valid = vld[NS];
  assign out_ch.data = obuf;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output word changed under stall");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data[4*DW] |-> out_ch.data[4*DW-1:DW] == '0)
    else $error("degenerate word not identity");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
`endif
endmodule

### test/rotation_matrix_to_quaternion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_checker
// Watches the matrix and quaternion channels, predicts each quaternion from
// the accepted matrix with the four-branch trace method and compares fields.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_checker #(
  parameter int DATA_WIDTH = rmq_pkg::DataWidthDefault,
  parameter int FRAC_BITS  = rmq_pkg::FracBitsDefault
) (
  input  logic  clk,
  input  logic  rst,
  rmq_stream_if in_ch,
  rmq_stream_if out_ch,
  output int    pending,
  output int    failures
);
  localparam longint WordMax = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint WordMin = -WordMax - 1;
  localparam longint OneQ    = 64'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic                  degenerate;
    logic [DATA_WIDTH-1:0] quat_z;
    logic [DATA_WIDTH-1:0] quat_y;
    logic [DATA_WIDTH-1:0] quat_x;
    logic [DATA_WIDTH-1:0] quat_w;
  } quat_t;

  quat_t quat_queue[$];

  function automatic longint clamp_word(longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint frac_divide(longint num, longint unsigned s);
    bit neg;
    longint unsigned mag;
    longint unsigned q;
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    q = (mag << FRAC_BITS) / s;
    if (q > longint'(WordMax) + 1) q = longint'(WordMax) + 1;
    return clamp_word(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t convert_matrix(logic [9*DATA_WIDTH-1:0] m);
    longint e[9];
    longint tr, r, w, x, y, z, quarter;
    longint unsigned h, s;
    rmq_pkg::branch_t br;
    quat_t q;
    for (int k = 0; k < 9; k++)
      e[k] = longint'($signed(m[k*DATA_WIDTH +: DATA_WIDTH]));
    tr = e[0] + e[4] + e[8];
    w = clamp_word(OneQ);
    x = 0;
    y = 0;
    z = 0;
    if (tr > 0) begin
      br = rmq_pkg::BR_TRACE;
      r = tr + OneQ;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      br = rmq_pkg::BR_X;
      r = OneQ + e[0] - e[4] - e[8];
    end else if (e[4] > e[8]) begin
      br = rmq_pkg::BR_Y;
      r = OneQ + e[4] - e[0] - e[8];
    end else begin
      br = rmq_pkg::BR_Z;
      r = OneQ + e[8] - e[0] - e[4];
    end
    q.degenerate = (r <= 0);
    if (r > 0) begin
      h = int_root(longint'(r) << FRAC_BITS);
      s = h * 2;
      quarter = clamp_word(longint'(h >> 1));
      case (br)
        rmq_pkg::BR_TRACE: begin
          w = quarter;
          x = frac_divide(e[7] - e[5], s);
          y = frac_divide(e[2] - e[6], s);
          z = frac_divide(e[3] - e[1], s);
        end
        rmq_pkg::BR_X: begin
          w = frac_divide(e[7] - e[5], s);
          x = quarter;
          y = frac_divide(e[1] + e[3], s);
          z = frac_divide(e[2] + e[6], s);
        end
        rmq_pkg::BR_Y: begin
          w = frac_divide(e[2] - e[6], s);
          x = frac_divide(e[1] + e[3], s);
          y = quarter;
          z = frac_divide(e[5] + e[7], s);
        end
        default: begin
          w = frac_divide(e[3] - e[1], s);
          x = frac_divide(e[2] + e[6], s);
          y = frac_divide(e[5] + e[7], s);
          z = quarter;
        end
      endcase
    end
    q.quat_w = w[DATA_WIDTH-1:0];
    q.quat_x = x[DATA_WIDTH-1:0];
    q.quat_y = y[DATA_WIDTH-1:0];
    q.quat_z = z[DATA_WIDTH-1:0];
    return q;
  endfunction

  assign pending = quat_queue.size();

  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (rst) begin
      failures <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) quat_queue.push_back(convert_matrix(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          failures <= failures + 1;
        end else begin
          want = quat_queue.pop_front();
          if (got !== want) begin
            if (got.quat_w !== want.quat_w)
              $display("%0t: quat_w expected %h actual %h", $time, want.quat_w, got.quat_w);
            if (got.quat_x !== want.quat_x)
              $display("%0t: quat_x expected %h actual %h", $time, want.quat_x, got.quat_x);
            if (got.quat_y !== want.quat_y)
              $display("%0t: quat_y expected %h actual %h", $time, want.quat_y, got.quat_y);
            if (got.quat_z !== want.quat_z)
              $display("%0t: quat_z expected %h actual %h", $time, want.quat_z, got.quat_z);
            if (got.degenerate !== want.degenerate)
              $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                       got.degenerate);
            failures <= failures + 1;
          end
        end
      end
    end
  end
endmodule

### test/rotation_matrix_to_quaternion_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core_test
// Drives directed and random matrices with random gaps and back-pressure;
// the checker predicts and compares every quaternion word.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_test;
  localparam int DW        = 16;
  localparam int RandItems = 550;
  localparam int Limit     = 400000;

  logic clk;
  logic rst;
  logic quiet;
  int   cycles = 0;
  int   pending;
  int   failures;

  rmq_stream_if #(.Width(9 * DW)) in_ch ();
  rmq_stream_if #(.Width(4 * DW + 1)) out_ch ();

  rotation_matrix_to_quaternion_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rotation_matrix_to_quaternion_checker chk (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .pending  (pending),
    .failures (failures)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_matrix(input logic [9*DW-1:0] m);
    if (!quiet && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [9*DW-1:0] diag_matrix(logic [DW-1:0] a, logic [DW-1:0] b,
                                                  logic [DW-1:0] c, logic [DW-1:0] off);
    return {c, off, ~off, off, b, ~off, off, off, a};
  endfunction

  function automatic logic [DW-1:0] rand_entry(int mode);
    case (mode)
      0: return DW'($urandom_range(0, 32768) - 16384);
      1: return DW'($urandom);
      default: return DW'($urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  initial begin
    logic [9*DW-1:0] m;
    int mode;
    quiet       = 0;
    rst         = 1;
    in_ch.valid = 0;
    in_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst <= 0;

    send_matrix(diag_matrix(16'h4000, 16'h4000, 16'h4000, 16'h0000));
    send_matrix('0);
    send_matrix(diag_matrix(16'hc000, 16'hc000, 16'hc000, 16'h0000));
    send_matrix(diag_matrix(16'h4000, 16'hc000, 16'hc000, 16'h1000));
    send_matrix(diag_matrix(16'hc000, 16'h4000, 16'hc000, 16'h2000));
    send_matrix(diag_matrix(16'hc000, 16'hc000, 16'h4000, 16'he000));
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h5555}});
    send_matrix({9{16'haaaa}});
    send_matrix(diag_matrix(16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
    send_matrix(diag_matrix(16'h8000, 16'h7fff, 16'h8000, 16'h8000));
    send_matrix(diag_matrix(16'h8000, 16'h8000, 16'h7fff, 16'h7fff));
    send_matrix(diag_matrix(16'h0001, 16'h0000, 16'hffff, 16'h7fff));
    send_matrix(diag_matrix(16'hb000, 16'hd800, 16'h7000, 16'h8000));
    send_matrix(diag_matrix(16'h0000, 16'h0000, 16'h0000, 16'h7fff));
    send_matrix(diag_matrix(16'h2000, 16'h2000, 16'hc000, 16'h8000));

    for (int i = 0; i < RandItems; i++) begin
      quiet = (i >= 200 && i < 300);
      if (i == 320) begin
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) m[k*DW +: DW] = rand_entry(mode);
      send_matrix(m);
    end
    quiet = 0;
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
